### rtl/utf8_script_ratio_filter_top_assert.svh
// Assertion macros shared by the script ratio filter top level.
`ifndef UTF8_SCRIPT_RATIO_FILTER_TOP_ASSERT_SVH
`define UTF8_SCRIPT_RATIO_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define USRF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define USRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/usrf_pkg.sv
// Types, constants and helpers shared by the script ratio filter modules.
package usrf_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int OUT_WIDTH = 24;
   localparam int CP_WIDTH = 21;
   localparam int THR_WIDTH = 7;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic [THR_WIDTH-1:0] PCT_FULL = 7'd100;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 4'd1;

   localparam logic [CP_WIDTH-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] CP_NEUTRAL_MAX = 21'h000040;
   localparam logic [CP_WIDTH-1:0] CP_PUNCT_LOW = 21'h002000;
   localparam logic [CP_WIDTH-1:0] CP_PUNCT_HIGH = 21'h00214F;
   localparam logic [CP_WIDTH-1:0] CP_LATIN_MAX = 21'h00036F;
   localparam logic [CP_WIDTH-1:0] CP_LATIN_EXT_LOW = 21'h001E00;
   localparam logic [CP_WIDTH-1:0] CP_LATIN_EXT_HIGH = 21'h001EFF;
   localparam logic [CP_WIDTH-1:0] CP_LATIN_D_LOW = 21'h00A720;
   localparam logic [CP_WIDTH-1:0] CP_LATIN_D_HIGH = 21'h00A7FF;

   localparam logic [7:0] BYTE_ASCII_END = 8'h80;
   localparam logic [7:0] BYTE_LEAD2_LOW = 8'hC2;
   localparam logic [7:0] BYTE_LEAD3_LOW = 8'hE0;
   localparam logic [7:0] BYTE_LEAD4_LOW = 8'hF0;
   localparam logic [7:0] BYTE_LEAD_END = 8'hF8;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       record_end;
   } req_type;

   typedef struct packed {
      logic                 flagged;
      logic [OUT_WIDTH-1:0] latin_count;
      logic [OUT_WIDTH-1:0] non_latin_count;
      logic [OUT_WIDTH-1:0] checked_total;
      logic [OUT_WIDTH-1:0] flagged_total;
   } rsp_type;

   typedef struct packed {
      logic latin;
      logic other;
      logic record_end;
   } class_type;

   typedef struct packed {
      logic                 enable;
      logic [THR_WIDTH-1:0] threshold;
   } cfg_type;

endpackage

### rtl/utf8_script_ratio_filter_top.sv
// Top level of the UTF-8 script ratio filter: registers, queues, decoder and tally unit.
//
//   channel  direction  handshake              beat
//   req      in         push / full            text byte and record end flag
//   rsp      out        pop / empty            flag, record counts and totals
//   csr      in         valid / ready          register index and write data
//
// One byte is accepted every cycle while the class queue has room.
// A result passes from its record end via the class queue, decision register and result queue.
// The decision register holds one record; a second record end waits only if it is not free.
// Synchronous reset clears the decoder, tallies, totals, queues and registers.
// A stalled result side fills the result queue, then the class queue, then raises full.
module utf8_script_ratio_filter_top #(
   parameter int COUNT_WIDTH = usrf_pkg::COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = usrf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  usrf_pkg::req_type                      req_data,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output usrf_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [usrf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [usrf_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import usrf_pkg::*;
`include "utf8_script_ratio_filter_top_assert.svh"

   cfg_type          cfg_ff, cfg_in;
   logic             accept;
   logic             cls_push, cls_pop, cls_full, cls_empty;
   class_type        cls_wr, cls_rd;
   logic             out_push, out_full;
   rsp_type          out_data;
   logic [THR_WIDTH-1:0] thr_wr;

   assign csr_ready = 1'b1;
   assign thr_wr = csr_wdata[THR_WIDTH-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE: cfg_in.enable = csr_wdata[0];
            CSR_THRESHOLD: cfg_in.threshold = (thr_wr > PCT_FULL) ? PCT_FULL : thr_wr;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = cls_full;
   assign accept = req_push && !req_full;

   usrf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cls_push (cls_push),
      .cls      (cls_wr)
   );

   usrf_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cls_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cls_push),
      .wdata (cls_wr),
      .full  (cls_full),
      .pop   (cls_pop),
      .rdata (cls_rd),
      .empty (cls_empty)
   );

   usrf_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cls       (cls_rd),
      .cls_empty (cls_empty),
      .cls_pop   (cls_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   usrf_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

   `USRF_ASSERT_IMPLY(a_flag_counted, !rsp_empty && rsp_data.flagged, rsp_data.flagged_total != '0, "flagged result with zero flagged total")
   `USRF_ASSERT_IMPLY(a_flag_le_checked, !rsp_empty, rsp_data.flagged_total <= rsp_data.checked_total, "flagged total exceeds checked total")
   `USRF_ASSERT_IMPLY(a_no_pop_empty, cls_pop, !cls_empty, "class queue popped while empty")
   `USRF_ASSERT_NEXT(a_push_not_empty, out_push, !rsp_empty, "result queue empty after a push")
endmodule

### rtl/usrf_fifo.sv
// Small register queue used between the decoder and the tally unit and at the result side.
module usrf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule

### rtl/usrf_front.sv
// UTF-8 decoder front end: beats for Latin or other code points and record ends.
module usrf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  usrf_pkg::req_type   req,
   output logic                cls_push,
   output usrf_pkg::class_type cls
);
   import usrf_pkg::*;

   logic [CP_WIDTH-1:0] cp_ff, cp_in;
   logic [1:0]          need_ff, need_in;
   logic [CP_WIDTH-1:0] cp_asm;
   logic [CP_WIDTH-1:0] cp_val;
   logic                cp_valid;
   logic                relead;
   logic [7:0]          b;
   logic                is_neutral, is_latin;

   assign b = req.text_byte;
   assign cp_asm = {cp_ff[CP_WIDTH-7:0], b[5:0]};

   always_comb begin
      cp_in = cp_ff;
      need_in = need_ff;
      cp_val = '0;
      cp_valid = 1'b0;
      relead = 1'b1;
      if (b == 8'h00) begin
         cp_in = '0;
         need_in = '0;
      end else begin
         if (need_ff != 2'd0) begin
            if (b[7:6] == 2'b10) begin
               relead = 1'b0;
               cp_in = cp_asm;
               need_in = need_ff - 2'd1;
               if (need_ff == 2'd1) begin
                  cp_valid = 1'b1;
                  cp_val = cp_asm;
               end
            end else begin
               cp_in = '0;
               need_in = '0;
            end
         end
         if (relead) begin
            if (b < BYTE_ASCII_END) begin
               cp_valid = 1'b1;
               cp_val = CP_WIDTH'(b);
            end else if (b < BYTE_LEAD2_LOW) begin
               cp_valid = 1'b0;
            end else if (b < BYTE_LEAD3_LOW) begin
               cp_in = CP_WIDTH'(b[4:0]);
               need_in = 2'd1;
            end else if (b < BYTE_LEAD4_LOW) begin
               cp_in = CP_WIDTH'(b[3:0]);
               need_in = 2'd2;
            end else if (b < BYTE_LEAD_END) begin
               cp_in = CP_WIDTH'(b[2:0]);
               need_in = 2'd3;
            end
         end
      end
      if (req.record_end) begin
         cp_in = '0;
         need_in = '0;
      end
   end

   assign is_neutral = (cp_val == CP_REPLACEMENT) || (cp_val <= CP_NEUTRAL_MAX) ||
                       ((cp_val >= CP_PUNCT_LOW) && (cp_val <= CP_PUNCT_HIGH));
   assign is_latin = (cp_val <= CP_LATIN_MAX) ||
                     ((cp_val >= CP_LATIN_EXT_LOW) && (cp_val <= CP_LATIN_EXT_HIGH)) ||
                     ((cp_val >= CP_LATIN_D_LOW) && (cp_val <= CP_LATIN_D_HIGH));

   always_comb begin
      cls.latin = cp_valid && !is_neutral && is_latin;
      cls.other = cp_valid && !is_neutral && !is_latin;
      cls.record_end = req.record_end;
   end

   assign cls_push = accept && (cls.latin || cls.other || cls.record_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff <= '0;
         need_ff <= '0;
      end else if (accept) begin
         cp_ff <= cp_in;
         need_ff <= need_in;
      end
   end
endmodule

### rtl/usrf_back.sv
// Tally unit that counts classes per record, decides the flag and keeps the totals.
module usrf_back #(
   parameter int COUNT_WIDTH = usrf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  usrf_pkg::cfg_type   cfg,
   input  usrf_pkg::class_type cls,
   input  logic                cls_empty,
   output logic                cls_pop,
   input  logic                out_full,
   output logic                out_push,
   output usrf_pkg::rsp_type   out_data
);
   import usrf_pkg::*;

   localparam int LW = COUNT_WIDTH + THR_WIDTH + 1;

   logic [COUNT_WIDTH-1:0] lat_ff, lat_in, non_ff, non_in;
   logic [COUNT_WIDTH-1:0] lat_nx, non_nx;
   logic [COUNT_WIDTH-1:0] dec_lat_ff, dec_non_ff;
   logic                   dec_valid_ff, dec_valid_in;
   logic [COUNT_WIDTH-1:0] checked_ff, checked_in, flagged_ff, flagged_in;
   logic                   dec_free, fire, active, flag;
   logic [COUNT_WIDTH:0]   total;
   logic [LW-1:0]          lhs, rhs;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (&v) ? v : v + 1'b1;
   endfunction

   assign fire = dec_valid_ff && !out_full;
   assign dec_free = !dec_valid_ff || fire;
   assign cls_pop = !cls_empty && (!cls.record_end || dec_free);

   assign lat_nx = cls.latin ? sat_inc(lat_ff) : lat_ff;
   assign non_nx = cls.other ? sat_inc(non_ff) : non_ff;

   always_comb begin
      lat_in = lat_ff;
      non_in = non_ff;
      dec_valid_in = dec_valid_ff && !fire;
      if (cls_pop) begin
         lat_in = cls.record_end ? '0 : lat_nx;
         non_in = cls.record_end ? '0 : non_nx;
         if (cls.record_end) begin
            dec_valid_in = 1'b1;
         end
      end
   end

   assign total = {1'b0, dec_lat_ff} + {1'b0, dec_non_ff};
   assign lhs = LW'(dec_non_ff) * LW'(PCT_FULL);
   assign rhs = LW'(cfg.threshold) * LW'(total);
   assign active = cfg.enable && (cfg.threshold != '0);
   assign flag = active && (total != '0) && (lhs >= rhs);

   always_comb begin
      checked_in = checked_ff;
      flagged_in = flagged_ff;
      if (fire && active) begin
         checked_in = sat_inc(checked_ff);
      end
      if (fire && flag) begin
         flagged_in = sat_inc(flagged_ff);
      end
   end

   assign out_push = fire;
   always_comb begin
      out_data.flagged = flag;
      out_data.latin_count = OUT_WIDTH'(dec_lat_ff);
      out_data.non_latin_count = OUT_WIDTH'(dec_non_ff);
      out_data.checked_total = OUT_WIDTH'(checked_in);
      out_data.flagged_total = OUT_WIDTH'(flagged_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
         non_ff <= '0;
         dec_valid_ff <= 1'b0;
         checked_ff <= '0;
         flagged_ff <= '0;
      end else begin
         lat_ff <= lat_in;
         non_ff <= non_in;
         dec_valid_ff <= dec_valid_in;
         checked_ff <= checked_in;
         flagged_ff <= flagged_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_pop && cls.record_end) begin
         dec_lat_ff <= lat_nx;
         dec_non_ff <= non_nx;
      end
   end
endmodule

### tb/sv/script_ratio_checker.sv
// Checker that predicts the script ratio filter's record verdicts and compares them.
module script_ratio_checker #(
   parameter int COUNT_WIDTH = usrf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  usrf_pkg::req_type                    req_data,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  usrf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [usrf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [usrf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                   pending_verdicts,
   output int                                   mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import usrf_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;
   localparam int PRINT_LIMIT = 200;

   logic                   enabled;
   logic [THR_WIDTH-1:0]   pct_limit;
   logic [CP_WIDTH-1:0]    cp_accum;
   logic [1:0]             cont_left;
   logic [COUNT_WIDTH-1:0] latin_tally_q;
   logic [COUNT_WIDTH-1:0] other_tally_q;
   logic [COUNT_WIDTH-1:0] checked_q;
   logic [COUNT_WIDTH-1:0] flagged_q;
   rsp_type                expected_verdicts[$];
   int                     errors = 0;

   assign mismatch_count = errors;

   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
      return (v == TALLY_MAX) ? v : v + 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_WIDTH-1:0] got,
                                  input logic [OUT_WIDTH-1:0] want);
      errors++;
      if (errors <= PRINT_LIMIT) begin
         $display("%0t ns: %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
      end
   endtask

   task automatic compare_field(input string what, input logic [OUT_WIDTH-1:0] got,
                                input logic [OUT_WIDTH-1:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic apply_setting(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_ENABLE: enabled = data[0];
         CSR_THRESHOLD: begin
            pct_limit = (data[THR_WIDTH-1:0] > PCT_FULL) ? PCT_FULL : data[THR_WIDTH-1:0];
         end
         default: ;
      endcase
   endtask

   task automatic tally_code_point(input logic [CP_WIDTH-1:0] cp);
      if (cp == CP_REPLACEMENT || cp <= CP_NEUTRAL_MAX ||
          (cp >= CP_PUNCT_LOW && cp <= CP_PUNCT_HIGH)) begin
      end else if (cp <= CP_LATIN_MAX ||
                   (cp >= CP_LATIN_EXT_LOW && cp <= CP_LATIN_EXT_HIGH) ||
                   (cp >= CP_LATIN_D_LOW && cp <= CP_LATIN_D_HIGH)) begin
         latin_tally_q = bump(latin_tally_q);
      end else begin
         other_tally_q = bump(other_tally_q);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic as_lead;
      as_lead = 1'b1;
      if (b == 8'h00) begin
         cont_left = '0;
         cp_accum = '0;
         as_lead = 1'b0;
      end else if (cont_left != 0) begin
         if (b[7:6] == 2'b10) begin
            cp_accum = {cp_accum[CP_WIDTH-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) begin
               tally_code_point(cp_accum);
            end
            as_lead = 1'b0;
         end else begin
            // A byte that breaks the sequence starts over as a lead byte.
            cont_left = '0;
            cp_accum = '0;
         end
      end
      if (as_lead) begin
         if (b < BYTE_ASCII_END) begin
            tally_code_point(CP_WIDTH'(b));
         end else if (b >= BYTE_LEAD2_LOW && b < BYTE_LEAD3_LOW) begin
            cp_accum = CP_WIDTH'(b[4:0]);
            cont_left = 2'd1;
         end else if (b >= BYTE_LEAD3_LOW && b < BYTE_LEAD4_LOW) begin
            cp_accum = CP_WIDTH'(b[3:0]);
            cont_left = 2'd2;
         end else if (b >= BYTE_LEAD4_LOW && b < BYTE_LEAD_END) begin
            cp_accum = CP_WIDTH'(b[2:0]);
            cont_left = 2'd3;
         end
      end
   endtask

   task automatic close_record();
      rsp_type         verdict;
      longint unsigned total;
      longint unsigned other_scaled;
      longint unsigned limit_scaled;
      verdict = '0;
      if (enabled && pct_limit != 0) begin
         total = 64'(latin_tally_q) + 64'(other_tally_q);
         other_scaled = 64'(other_tally_q) * 64'(PCT_FULL);
         limit_scaled = 64'(pct_limit) * total;
         checked_q = bump(checked_q);
         if (total != 0 && other_scaled >= limit_scaled) begin
            verdict.flagged = 1'b1;
            flagged_q = bump(flagged_q);
         end
      end
      verdict.latin_count = OUT_WIDTH'(latin_tally_q);
      verdict.non_latin_count = OUT_WIDTH'(other_tally_q);
      verdict.checked_total = OUT_WIDTH'(checked_q);
      verdict.flagged_total = OUT_WIDTH'(flagged_q);
      expected_verdicts.push_back(verdict);
      latin_tally_q = '0;
      other_tally_q = '0;
      cp_accum = '0;
      cont_left = '0;
   endtask

   task automatic check_verdict(input rsp_type got);
      rsp_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch("result beat with no closed record", got.latin_count, '0);
      end else begin
         want = expected_verdicts.pop_front();
         compare_field("flagged", OUT_WIDTH'(got.flagged), OUT_WIDTH'(want.flagged));
         compare_field("latin_count", got.latin_count, want.latin_count);
         compare_field("non_latin_count", got.non_latin_count, want.non_latin_count);
         compare_field("checked_total", got.checked_total, want.checked_total);
         compare_field("flagged_total", got.flagged_total, want.flagged_total);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         enabled = 1'b0;
         pct_limit = '0;
         cp_accum = '0;
         cont_left = '0;
         latin_tally_q = '0;
         other_tally_q = '0;
         checked_q = '0;
         flagged_q = '0;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_setting(csr_index, csr_wdata);
         end
         if (rsp_pop && !rsp_empty) begin
            check_verdict(rsp_data);
         end
         if (req_push && !req_full) begin
            decode_byte(req_data.text_byte);
            if (req_data.record_end) begin
               close_record();
            end
         end
      end
      pending_verdicts <= expected_verdicts.size();
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the script ratio filter: clock, reset, byte stimulus and final verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import usrf_pkg::*;

   localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam int RESET_CYCLES = 4;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int HOLD_PHASE = 3;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic                       req_full;
   req_type                    req_data;
   logic                       rsp_empty;
   logic                       rsp_pop;
   rsp_type                    rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   int pending_verdicts;
   int mismatch_count;
   int cycle_count = 0;
   int items_sent = 0;
   int hold_requests = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;

   utf8_script_ratio_filter_top #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   script_ratio_checker #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) verdict_check (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .pending_verdicts(pending_verdicts),
      .mismatch_count(mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] enable_data,
                            input logic [CSR_DATA_WIDTH-1:0] pct_data);
      csr_write(CSR_ENABLE, enable_data);
      csr_write(CSR_THRESHOLD, pct_data);
      // An index past the register map must leave the settings alone.
      csr_write(CSR_INDEX_WIDTH'($urandom_range(int'(CSR_THRESHOLD) + 1,
                                                (1 << CSR_INDEX_WIDTH) - 1)),
                CSR_DATA_WIDTH'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic push_item(input req_type beat);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_verdicts != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_record(input bit garbled);
      logic [7:0]          text[$];
      logic [7:0]          enc[4];
      logic [CP_WIDTH-1:0] cp;
      req_type             beat;
      int                  chars;
      int                  bias;
      int                  len;
      int                  keep;
      int                  roll;
      chars = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      bias = $urandom_range(0, 100);
      for (int c = 0; c < chars; c++) begin
         roll = $urandom_range(0, 99);
         if (garbled || roll < 6) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else if (roll < 9) begin
            text.push_back(8'h00);
         end else begin
            if ($urandom_range(0, 99) < bias) begin
               case ($urandom_range(0, 2))
                  0: cp = CP_WIDTH'($urandom_range(32'h0370, 32'h07FF));
                  1: cp = CP_WIDTH'($urandom_range(32'h0800, 32'hFFFF));
                  default: cp = CP_WIDTH'($urandom_range(32'h010000, 32'h1FFFFF));
               endcase
            end else begin
               case ($urandom_range(0, 5))
                  0: cp = CP_WIDTH'($urandom_range(32'h41, 32'h7F));
                  1: cp = CP_WIDTH'($urandom_range(32'h0080, 32'h036F));
                  2: cp = CP_WIDTH'($urandom_range(32'h1E00, 32'h1EFF));
                  3: cp = CP_WIDTH'($urandom_range(32'hA720, 32'hA7FF));
                  4: cp = CP_WIDTH'(roll[0] ? $urandom_range(1, 32'h40)
                                            : $urandom_range(32'h2000, 32'h214F));
                  default: begin
                     case ($urandom_range(0, 8))
                        0: cp = CP_NEUTRAL_MAX;
                        1: cp = CP_LATIN_MAX;
                        2: cp = CP_LATIN_EXT_LOW - 1'b1;
                        3: cp = CP_LATIN_EXT_HIGH;
                        4: cp = CP_PUNCT_LOW - 1'b1;
                        5: cp = CP_PUNCT_HIGH;
                        6: cp = CP_LATIN_D_LOW - 1'b1;
                        7: cp = CP_LATIN_D_HIGH;
                        default: cp = CP_REPLACEMENT - 1'b1;
                     endcase
                     cp = cp + CP_WIDTH'($urandom_range(0, 2));
                  end
               endcase
            end
            len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            if (len < 4 && $urandom_range(0, 15) == 0) begin
               len = len + 1;
            end
            keep = (len > 1 && $urandom_range(0, 19) == 0) ? $urandom_range(1, len - 1) : len;
            case (len)
               1: enc[0] = cp[7:0];
               2: begin
                  enc[0] = {3'b110, cp[10:6]};
                  enc[1] = {2'b10, cp[5:0]};
               end
               3: begin
                  enc[0] = {4'b1110, cp[15:12]};
                  enc[1] = {2'b10, cp[11:6]};
                  enc[2] = {2'b10, cp[5:0]};
               end
               default: begin
                  enc[0] = {5'b11110, cp[20:18]};
                  enc[1] = {2'b10, cp[17:12]};
                  enc[2] = {2'b10, cp[11:6]};
                  enc[3] = {2'b10, cp[5:0]};
               end
            endcase
            for (int i = 0; i < keep; i++) begin
               text.push_back(enc[i]);
            end
         end
      end
      if (text.size() == 0 || $urandom_range(0, 3) == 0) begin
         text.push_back(8'($urandom_range(0, 255)));
      end
      foreach (text[i]) begin
         beat.text_byte = text[i];
         beat.record_end = (i == text.size() - 1);
         push_item(beat);
      end
   endtask

   initial begin
      int gap;
      int holds_served;
      holds_served = 0;
      rsp_pop <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = receiver_steady ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin
      logic [8:0]                sample[$];
      logic [CSR_DATA_WIDTH-1:0] enable_data;
      logic [CSR_DATA_WIDTH-1:0] pct_data;
      int                        target;
      bit                        steady;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Mixed record: Latin, neutral, replacement, four-byte, broken and stray bytes,
      // closed in the middle of a sequence; then a record closed by a completing byte
      // and an empty record.
      configure(8'h01, 8'd40);
      sample = '{{8'h41, 1'b0}, {8'h40, 1'b0}, {8'hC3, 1'b0}, {8'hA9, 1'b0},
                 {8'hD0, 1'b0}, {8'h96, 1'b0}, {8'hE2, 1'b0}, {8'h80, 1'b0},
                 {8'h94, 1'b0}, {8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBD, 1'b0},
                 {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b0},
                 {8'hC3, 1'b0}, {8'h41, 1'b0}, {8'hE3, 1'b0}, {8'h81, 1'b0},
                 {8'h00, 1'b0}, {8'h80, 1'b0}, {8'hFF, 1'b0}, {8'hC1, 1'b0},
                 {8'hE3, 1'b1}, {8'hC3, 1'b0}, {8'hA9, 1'b1}, {8'h00, 1'b1}};
      foreach (sample[i]) begin
         push_item(req_type'(sample[i]));
      end
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin enable_data = 8'h01; pct_data = CSR_DATA_WIDTH'(PCT_FULL); end
            1: begin enable_data = 8'hFF; pct_data = 8'd1; end
            2: begin enable_data = 8'hFE; pct_data = 8'd50; end
            3: begin enable_data = 8'h01; pct_data = 8'd0; end
            4: begin enable_data = 8'h01; pct_data = 8'd127; end
            5: begin enable_data = 8'h01; pct_data = 8'hFF; end
            default: begin
               enable_data = CSR_DATA_WIDTH'($urandom);
               pct_data = CSR_DATA_WIDTH'(($urandom_range(0, 3) == 0) ? $urandom
                                                                     : $urandom_range(1, 100));
            end
         endcase
         configure(enable_data, pct_data);
         steady = (p == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
         sender_steady <= steady;
         receiver_steady <= ($urandom_range(0, 3) == 0);
         if (p == HOLD_PHASE) begin
            hold_requests <= hold_requests + 1;
         end
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            send_record($urandom_range(0, 7) == 0);
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
